FILE: hdl/assert_macros.svh
// assertion macros shared by the tracer modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion with reset disable
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// clocked assertion with reset disable and a message
`define ASSERT_CLK_MSG(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

`endif

FILE: hdl/mbt_pkg.sv
// types, codes and helpers for the moore boundary tracer
package mbt_pkg;

  localparam int DEF_MAX_ROWS   = 256;
  localparam int DEF_MAX_COLS   = 256;
  localparam int DEF_MAX_POINTS = 4096;

  localparam int CRD_W = 10;  // signed coordinate, covers -2..257

  localparam logic       REQ_WRITE = 1'b0;
  localparam logic       REQ_STEP  = 1'b1;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_NO_FG    = 2'd1;
  localparam logic [1:0] STATUS_DEAD_END = 2'd2;
  localparam logic [1:0] STATUS_OVERLONG = 2'd3;

  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_STARTED = 2'd1;
  localparam logic [1:0] PH_TRACING = 2'd2;
  localparam logic [1:0] PH_OVER    = 2'd3;

  localparam logic [8:0] RESET_SIZE = 9'd256;

  typedef struct packed {
    logic       req_type;
    logic [7:0] pixel_row;
    logic [7:0] pixel_col;
    logic       pixel_value;
  } in_word_t;

  typedef struct packed {
    logic [7:0] point_row;
    logic [7:0] point_col;
    logic       point_valid;
    logic       trace_done;
    logic [1:0] status;
  } out_word_t;

  typedef struct packed {
    logic wr_pixel;
    logic step_begin;
    logic scan_rd;
    logic scan_chk;
    logic pix_rd;
    logic pix_chk;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] phase;
    logic       empty;
    logic       scan_stop;
    logic       pt_done;
    logic       pr_retry;
    logic       strobe;
  } dp_stat_t;

  function automatic logic signed [CRD_W-1:0] oct_dr(input logic [2:0] k);
    logic signed [CRD_W-1:0] d;
    unique case (k)
      3'd0, 3'd1, 3'd7: d = 10'sd1;
      3'd2, 3'd6:       d = 10'sd0;
      default:          d = -10'sd1;
    endcase
    return d;
  endfunction

  function automatic logic signed [CRD_W-1:0] oct_dc(input logic [2:0] k);
    logic signed [CRD_W-1:0] d;
    unique case (k)
      3'd1, 3'd2, 3'd3: d = 10'sd1;
      3'd0, 3'd4:       d = 10'sd0;
      default:          d = -10'sd1;
    endcase
    return d;
  endfunction

  function automatic logic in_img(input logic signed [CRD_W-1:0] r,
                                  input logic signed [CRD_W-1:0] c,
                                  input logic [8:0] nr,
                                  input logic [8:0] nc);
    return (r >= 0) && (c >= 0) &&
           (r < $signed({1'b0, nr})) && (c < $signed({1'b0, nc}));
  endfunction

endpackage

FILE: hdl/moore_boundary_tracer.sv
// top level of the moore neighbor boundary tracer
// a write, an empty-image step or a step after the trace ends answers in the next cycle
// a first step reads then checks each pixel it scans; a later step reads then checks each window pixel,
//   1 to 9 pixels per direction probed, at most 8 directions, single-port store
// throughput: one word at a time, busy high while a step works; results cannot stall
// reset: synchronous active low, trace restarts, sizes 256, bit store not cleared
module moore_boundary_tracer #(
  parameter int MAX_ROWS   = mbt_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS   = mbt_pkg::DEF_MAX_COLS,
  parameter int MAX_POINTS = mbt_pkg::DEF_MAX_POINTS
) (
  input  logic               clk,
  input  logic               rst_n,
  // input word channel
  input  logic               start,
  output logic               busy,
  input  mbt_pkg::in_word_t  in_data,
  // result word channel, one strobe per word
  output logic               out_strobe,
  output mbt_pkg::out_word_t out_data,
  // register port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  mbt_pkg::dp_cmd_t  cmd;
  mbt_pkg::dp_stat_t stat;
  logic [8:0]        rows_cfg, cols_cfg;
  logic              cfg_we;

  // register file: rows at offset 0, columns at offset 4
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite & pready;
  assign prdata = {23'd0, paddr[2] ? cols_cfg : rows_cfg};

  // controller sequences scan reads and the per-direction window reads
  mbt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .req_type (in_data.req_type),
    .stat     (stat),
    .cmd      (cmd),
    .busy     (busy)
  );

  // datapath holds the bit store, trace state and the result word
  mbt_datapath #(
    .MAX_ROWS   (MAX_ROWS),
    .MAX_COLS   (MAX_COLS),
    .MAX_POINTS (MAX_POINTS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_data    (in_data),
    .cmd        (cmd),
    .cfg_we     (cfg_we),
    .cfg_sel    (paddr[2]),
    .cfg_wdata  (pwdata[8:0]),
    .stat       (stat),
    .rows_cfg   (rows_cfg),
    .cols_cfg   (cols_cfg),
    .out_data   (out_data),
    .out_strobe (out_strobe)
  );

endmodule

FILE: hdl/mbt_ctrl.sv
// sequencer for pixel writes, start scan and neighbor probes
`include "assert_macros.svh"

module mbt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              req_type,
  input  mbt_pkg::dp_stat_t stat,
  output mbt_pkg::dp_cmd_t  cmd,
  output logic              busy
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN_A, ST_SCAN_B, ST_PIX_A, ST_PIX_B
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (req_type == mbt_pkg::REQ_WRITE) begin
            cmd.wr_pixel = 1'b1;
          end else begin
            cmd.step_begin = 1'b1;
            if (stat.phase == mbt_pkg::PH_IDLE && !stat.empty) begin
              state_nxt = ST_SCAN_A;
            end else if (stat.phase == mbt_pkg::PH_STARTED ||
                         stat.phase == mbt_pkg::PH_TRACING) begin
              state_nxt = ST_PIX_A;
            end
          end
        end
      end
      ST_SCAN_A: begin
        cmd.scan_rd = 1'b1;
        state_nxt   = ST_SCAN_B;
      end
      ST_SCAN_B: begin
        cmd.scan_chk = 1'b1;
        state_nxt    = stat.scan_stop ? ST_IDLE : ST_SCAN_A;
      end
      ST_PIX_A: begin
        cmd.pix_rd = 1'b1;
        state_nxt  = ST_PIX_B;
      end
      ST_PIX_B: begin
        cmd.pix_chk = 1'b1;
        state_nxt   = (stat.pt_done && !stat.pr_retry) ? ST_IDLE : ST_PIX_A;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

  `ASSERT_CLK(a_strobe_idle, clk, rst_n, stat.strobe |-> !busy)
  `ASSERT_CLK(a_chk_after_rd, clk, rst_n, state_r == ST_PIX_B |-> $past(state_r == ST_PIX_A))
  `ASSERT_CLK(a_step_answers, clk, rst_n, (start && !busy) |=> (busy || stat.strobe))

endmodule

FILE: hdl/mbt_datapath.sv
// bit store, trace registers, edge test and result register
`include "assert_macros.svh"

module mbt_datapath #(
  parameter int MAX_ROWS   = mbt_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS   = mbt_pkg::DEF_MAX_COLS,
  parameter int MAX_POINTS = mbt_pkg::DEF_MAX_POINTS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  mbt_pkg::in_word_t  in_data,
  input  mbt_pkg::dp_cmd_t   cmd,
  input  logic               cfg_we,
  input  logic               cfg_sel,
  input  logic [8:0]         cfg_wdata,
  output mbt_pkg::dp_stat_t  stat,
  output logic [8:0]         rows_cfg,
  output logic [8:0]         cols_cfg,
  output mbt_pkg::out_word_t out_data,
  output logic               out_strobe
);

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = $clog2(MAX_POINTS + 1);
  localparam int CW    = mbt_pkg::CRD_W;

  logic mem [DEPTH];

  logic [8:0]      rows_r, cols_r, img_rows, img_cols;
  logic            q_r, rd_ok_r, pixv;
  logic [1:0]      phase_r;
  logic [7:0]      start_row_r, start_col_r, cur_row_r, cur_col_r;
  logic [7:0]      base_row_r, base_col_r, scan_row_r, scan_col_r;
  logic [2:0]      dir_r, k_r, probe_r, jk;
  logic [3:0]      j_r;
  logic [PW-1:0]   pts_r;
  mbt_pkg::out_word_t res_r;
  logic            strobe_r;

  logic signed [CW-1:0] tgt_row, tgt_col, pj_row, pj_col, rd_row, rd_col;
  logic signed [CW-1:0] fb_row, fb_col;
  logic            rd_ok, pts_full, scan_last, pt_edge, pt_done, pr_retry;
  logic [2:0]      fb_k;
  logic [AW-1:0]   raddr, waddr;
  mbt_pkg::out_word_t res_point;

  assign img_rows = (rows_r < 9'(MAX_ROWS) || MAX_ROWS > 256) ? rows_r : 9'(MAX_ROWS);
  assign img_cols = (cols_r < 9'(MAX_COLS) || MAX_COLS > 256) ? cols_r : 9'(MAX_COLS);

  // probe target and the pixel of its 3x3 window being read
  assign jk      = 3'(j_r - 4'd1);
  assign tgt_row = $signed({2'b00, base_row_r}) + mbt_pkg::oct_dr(k_r);
  assign tgt_col = $signed({2'b00, base_col_r}) + mbt_pkg::oct_dc(k_r);
  assign pj_row  = tgt_row + ((j_r == 4'd0) ? '0 : mbt_pkg::oct_dr(jk));
  assign pj_col  = tgt_col + ((j_r == 4'd0) ? '0 : mbt_pkg::oct_dc(jk));
  assign rd_row  = cmd.scan_rd ? $signed({2'b00, scan_row_r}) : pj_row;
  assign rd_col  = cmd.scan_rd ? $signed({2'b00, scan_col_r}) : pj_col;
  assign rd_ok   = mbt_pkg::in_img(rd_row, rd_col, img_rows, img_cols);
  assign raddr   = rd_ok ? (AW'(rd_row[7:0]) + AW'(rd_col[7:0]) * AW'(MAX_ROWS)) : '0;
  assign waddr   = AW'(in_data.pixel_row) + AW'(in_data.pixel_col) * AW'(MAX_ROWS);

  assign pixv      = rd_ok_r & q_r;
  assign pts_full  = (pts_r >= PW'(MAX_POINTS));
  assign scan_last = ({1'b0, scan_row_r} == img_rows - 9'd1) &&
                     ({1'b0, scan_col_r} == img_cols - 9'd1);
  assign pt_edge   = (j_r != 4'd0) && !pixv;
  assign pt_done   = !pixv || (j_r == 4'd8);
  assign pr_retry  = pt_done && !pt_edge &&
                     ((phase_r == mbt_pkg::PH_STARTED) ? (k_r == 3'd3) : (probe_r != 3'd7));

  // second point fallback is the diagonal octant
  assign fb_k   = pt_edge ? k_r : 3'd1;
  assign fb_row = $signed({2'b00, base_row_r}) + mbt_pkg::oct_dr(fb_k);
  assign fb_col = $signed({2'b00, base_col_r}) + mbt_pkg::oct_dc(fb_k);

  always_comb begin
    res_point             = '0;
    res_point.point_row   = tgt_row[7:0];
    res_point.point_col   = tgt_col[7:0];
    res_point.point_valid = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_pixel && in_data.pixel_row < MAX_ROWS && in_data.pixel_col < MAX_COLS) begin
      mem[waddr] <= in_data.pixel_value;
    end
    if (cmd.scan_rd || cmd.pix_rd) begin
      q_r     <= mem[raddr];
      rd_ok_r <= rd_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r      <= mbt_pkg::RESET_SIZE;
      cols_r      <= mbt_pkg::RESET_SIZE;
      phase_r     <= mbt_pkg::PH_IDLE;
      pts_r       <= '0;
      strobe_r    <= 1'b0;
      start_row_r <= '0;
      start_col_r <= '0;
      cur_row_r   <= '0;
      cur_col_r   <= '0;
      dir_r       <= '0;
    end else begin
      strobe_r <= 1'b0;
      if (cfg_we) begin
        if (cfg_sel) cols_r <= cfg_wdata;
        else         rows_r <= cfg_wdata;
        phase_r <= mbt_pkg::PH_IDLE;
        pts_r   <= '0;
      end
      if (cmd.wr_pixel) begin
        phase_r  <= mbt_pkg::PH_IDLE;
        pts_r    <= '0;
        res_r    <= '0;
        strobe_r <= 1'b1;
      end
      if (cmd.step_begin) begin
        j_r     <= '0;
        probe_r <= '0;
        unique case (phase_r)
          mbt_pkg::PH_IDLE: begin
            scan_row_r <= '0;
            scan_col_r <= '0;
            if (img_rows == 9'd0 || img_cols == 9'd0) begin
              res_r        <= '0;
              res_r.status <= mbt_pkg::STATUS_NO_FG;
              strobe_r     <= 1'b1;
            end
          end
          mbt_pkg::PH_STARTED: begin
            base_row_r <= start_row_r;
            base_col_r <= start_col_r;
            k_r        <= 3'd3;
          end
          mbt_pkg::PH_TRACING: begin
            base_row_r <= cur_row_r;
            base_col_r <= cur_col_r;
            k_r        <= dir_r + 3'd3;
          end
          default: begin
            res_r    <= '0;
            strobe_r <= 1'b1;
          end
        endcase
      end
      if (cmd.scan_chk) begin
        if (pixv) begin
          start_row_r <= scan_row_r;
          start_col_r <= scan_col_r;
          cur_row_r   <= scan_row_r;
          cur_col_r   <= scan_col_r;
          phase_r     <= mbt_pkg::PH_STARTED;
          pts_r       <= PW'(1);
          res_r       <= '0;
          res_r.point_row   <= scan_row_r;
          res_r.point_col   <= scan_col_r;
          res_r.point_valid <= 1'b1;
          strobe_r    <= 1'b1;
        end else if (scan_last) begin
          res_r        <= '0;
          res_r.status <= mbt_pkg::STATUS_NO_FG;
          strobe_r     <= 1'b1;
        end else if ({1'b0, scan_row_r} == img_rows - 9'd1) begin
          scan_row_r <= '0;
          scan_col_r <= scan_col_r + 8'd1;
        end else begin
          scan_row_r <= scan_row_r + 8'd1;
        end
      end
      if (cmd.pix_chk) begin
        if (!pt_done) begin
          j_r <= j_r + 4'd1;
        end else if (pr_retry) begin
          j_r     <= '0;
          k_r     <= k_r - 3'd1;
          probe_r <= probe_r + 3'd1;
        end else if (phase_r == mbt_pkg::PH_STARTED) begin
          if (!mbt_pkg::in_img(fb_row, fb_col, img_rows, img_cols)) begin
            phase_r      <= mbt_pkg::PH_OVER;
            res_r        <= '0;
            res_r.status <= mbt_pkg::STATUS_DEAD_END;
          end else begin
            dir_r   <= fb_k;
            phase_r <= mbt_pkg::PH_TRACING;
            if (pts_full) begin
              phase_r      <= mbt_pkg::PH_OVER;
              res_r        <= '0;
              res_r.status <= mbt_pkg::STATUS_OVERLONG;
            end else begin
              pts_r     <= pts_r + PW'(1);
              cur_row_r <= fb_row[7:0];
              cur_col_r <= fb_col[7:0];
              res_r     <= '0;
              res_r.point_row   <= fb_row[7:0];
              res_r.point_col   <= fb_col[7:0];
              res_r.point_valid <= 1'b1;
            end
          end
          strobe_r <= 1'b1;
        end else begin
          if (!pt_edge) begin
            phase_r      <= mbt_pkg::PH_OVER;
            res_r        <= '0;
            res_r.status <= mbt_pkg::STATUS_DEAD_END;
          end else begin
            dir_r <= k_r;
            if (tgt_row[7:0] == start_row_r && tgt_col[7:0] == start_col_r) begin
              cur_row_r        <= tgt_row[7:0];
              cur_col_r        <= tgt_col[7:0];
              phase_r          <= mbt_pkg::PH_OVER;
              res_r            <= '0;
              res_r.trace_done <= 1'b1;
            end else if (pts_full) begin
              phase_r      <= mbt_pkg::PH_OVER;
              res_r        <= '0;
              res_r.status <= mbt_pkg::STATUS_OVERLONG;
            end else begin
              pts_r     <= pts_r + PW'(1);
              cur_row_r <= tgt_row[7:0];
              cur_col_r <= tgt_col[7:0];
              res_r     <= res_point;
            end
          end
          strobe_r <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    stat           = '0;
    stat.phase     = phase_r;
    stat.empty     = (img_rows == 9'd0) || (img_cols == 9'd0);
    stat.scan_stop = pixv || scan_last;
    stat.pt_done   = pt_done;
    stat.pr_retry  = pr_retry;
    stat.strobe    = strobe_r;
  end

  assign rows_cfg   = rows_r;
  assign cols_cfg   = cols_r;
  assign out_data   = res_r;
  assign out_strobe = strobe_r;

  `ASSERT_CLK(a_idle_no_points, clk, rst_n, phase_r == mbt_pkg::PH_IDLE |-> pts_r == '0)
  `ASSERT_CLK(a_pts_bounded, clk, rst_n, pts_r <= PW'(MAX_POINTS))

endmodule

FILE: test/mbt_checker.sv
// checker for the boundary tracer: watches both channels, predicts each result word and compares
module mbt_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  mbt_pkg::in_word_t  in_data,
  input  logic               out_strobe,
  input  mbt_pkg::out_word_t out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STORE_ROWS = mbt_pkg::DEF_MAX_ROWS;
  localparam int STORE_COLS = mbt_pkg::DEF_MAX_COLS;
  localparam int POINT_CAP  = mbt_pkg::DEF_MAX_POINTS;

  localparam int ROWS_REG = 0;
  localparam int COLS_REG = 1;

  bit        mask_bits [STORE_ROWS*STORE_COLS];
  logic [8:0] rows_n, cols_n;
  int        start_r, start_c, cur_r, cur_c;
  logic [2:0] move_dir;
  logic [1:0] phase;
  int        npoints;
  mbt_pkg::out_word_t expected_points[$];

  int step_dr [8] = '{1, 1, 0, -1, -1, -1, 0, 1};
  int step_dc [8] = '{0, 1, 1, 1, 0, -1, -1, -1};

  function automatic int used_rows();
    return (rows_n < STORE_ROWS) ? int'(rows_n) : STORE_ROWS;
  endfunction

  function automatic int used_cols();
    return (cols_n < STORE_COLS) ? int'(cols_n) : STORE_COLS;
  endfunction

  function automatic bit inside_img(int r, int c);
    return r >= 0 && c >= 0 && r < used_rows() && c < used_cols();
  endfunction

  function automatic bit pixel_at(int r, int c);
    if (!inside_img(r, c)) return 1'b0;
    return mask_bits[r + c*STORE_ROWS];
  endfunction

  function automatic bit edge_at(int r, int c);
    if (!pixel_at(r, c)) return 1'b0;
    for (int k = 0; k < 8; k++)
      if (!pixel_at(r + step_dr[k], c + step_dc[k])) return 1'b1;
    return 1'b0;
  endfunction

  function automatic mbt_pkg::out_word_t new_point(int r, int c);
    mbt_pkg::out_word_t o;
    o = '0;
    if (npoints >= POINT_CAP) begin
      phase = mbt_pkg::PH_OVER;
      o.status = mbt_pkg::STATUS_OVERLONG;
      return o;
    end
    npoints++;
    cur_r = r;
    cur_c = c;
    o.point_row = r[7:0];
    o.point_col = c[7:0];
    o.point_valid = 1'b1;
    return o;
  endfunction

  // next result word of a step (a boundary point, trace end or status), or the answer to a pixel write
  function automatic mbt_pkg::out_word_t next_boundary(mbt_pkg::in_word_t w);
    mbt_pkg::out_word_t o;
    int r, c, nr, nc, probe;
    logic [2:0] k;
    o = '0;
    if (w.req_type == mbt_pkg::REQ_WRITE) begin
      mask_bits[int'(w.pixel_row) + int'(w.pixel_col)*STORE_ROWS] = w.pixel_value;
      phase = mbt_pkg::PH_IDLE;
      npoints = 0;
      return o;
    end
    case (phase)
      mbt_pkg::PH_IDLE: begin
        for (c = 0; c < used_cols(); c++)
          for (r = 0; r < used_rows(); r++)
            if (pixel_at(r, c)) begin
              start_r = r;
              start_c = c;
              npoints = 0;
              phase = mbt_pkg::PH_STARTED;
              return new_point(r, c);
            end
        o.status = mbt_pkg::STATUS_NO_FG;
      end
      mbt_pkg::PH_STARTED: begin
        r = start_r;
        c = start_c;
        if (edge_at(r - 1, c + 1)) k = 3'd3;
        else if (edge_at(r, c + 1)) k = 3'd2;
        else k = 3'd1;
        nr = r + step_dr[k];
        nc = c + step_dc[k];
        if (!inside_img(nr, nc)) begin
          phase = mbt_pkg::PH_OVER;
          o.status = mbt_pkg::STATUS_DEAD_END;
          return o;
        end
        move_dir = k;
        phase = mbt_pkg::PH_TRACING;
        return new_point(nr, nc);
      end
      mbt_pkg::PH_TRACING: begin
        r = cur_r;
        c = cur_c;
        k = move_dir + 3'd3;
        for (probe = 0; probe < 8; probe++) begin
          if (edge_at(r + step_dr[k], c + step_dc[k])) break;
          k = k - 3'd1;
        end
        if (probe == 8) begin
          phase = mbt_pkg::PH_OVER;
          o.status = mbt_pkg::STATUS_DEAD_END;
          return o;
        end
        move_dir = k;
        nr = r + step_dr[k];
        nc = c + step_dc[k];
        if (nr == start_r && nc == start_c) begin
          cur_r = nr;
          cur_c = nc;
          phase = mbt_pkg::PH_OVER;
          o.trace_done = 1'b1;
          return o;
        end
        return new_point(nr, nc);
      end
      default: ;
    endcase
    return o;
  endfunction

  task automatic report(string what, int want, int got);
    $display("mismatch at %0t: %s expected %0d got %0d", $time, what, want, got);
    fail_count++;
  endtask

  always @(posedge clk) begin
    mbt_pkg::out_word_t want;
    if (!rst_n) begin
      rows_n = mbt_pkg::RESET_SIZE;
      cols_n = mbt_pkg::RESET_SIZE;
      start_r = 0; start_c = 0; cur_r = 0; cur_c = 0;
      move_dir = '0;
      phase = mbt_pkg::PH_IDLE;
      npoints = 0;
      expected_points.delete();
    end else begin
      if (out_strobe) begin
        if (expected_points.size() == 0) begin
          report("unexpected word", 0, 1);
        end else begin
          want = expected_points.pop_front();
          if (out_data.point_row !== want.point_row)
            report("point_row", want.point_row, out_data.point_row);
          if (out_data.point_col !== want.point_col)
            report("point_col", want.point_col, out_data.point_col);
          if (out_data.point_valid !== want.point_valid)
            report("point_valid", want.point_valid, out_data.point_valid);
          if (out_data.trace_done !== want.trace_done)
            report("trace_done", want.trace_done, out_data.trace_done);
          if (out_data.status !== want.status)
            report("status", want.status, out_data.status);
        end
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == ROWS_REG[0]) rows_n = pwdata[8:0];
        else cols_n = pwdata[8:0];
        phase = mbt_pkg::PH_IDLE;
        npoints = 0;
      end
      if (start && !busy) expected_points = {expected_points, next_boundary(in_data)};
    end
    pending = expected_points.size();
  end
endmodule

FILE: test/tb_moore_boundary_tracer.sv
// top of the boundary tracer testbench: clock, reset, stimulus and verdict
module tb_moore_boundary_tracer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 4000000;

  // shape codes for painting the image in use
  localparam int SHAPE_EMPTY  = 0;
  localparam int SHAPE_FULL   = 1;
  localparam int SHAPE_RECT   = 2;
  localparam int SHAPE_BLOB   = 3;
  localparam int SHAPE_SINGLE = 4;
  localparam int SHAPE_NOISE  = 5;

  localparam logic [2:0] ROWS_ADDR = 3'd0;
  localparam logic [2:0] COLS_ADDR = 3'd4;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  mbt_pkg::in_word_t  in_data = '0;
  logic               out_strobe;
  mbt_pkg::out_word_t out_data;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  int fail_count, pending;
  int cycle_count = 0;
  bit gaps_on = 1'b1;

  moore_boundary_tracer u_dut (
    .clk(clk), .rst_n(rst_n),
    .start(start), .busy(busy), .in_data(in_data),
    .out_strobe(out_strobe), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  mbt_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .start(start), .busy(busy), .in_data(in_data),
    .out_strobe(out_strobe), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // hard stop if the block hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tb_moore_boundary_tracer NOT OK");
      $finish;
    end
  end

  // present one word; start stays high afterwards so back-to-back words need no re-raise
  task automatic send_word(mbt_pkg::in_word_t w);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    start <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (busy);
  endtask

  task automatic send_pixel(int r, int c, bit v);
    mbt_pkg::in_word_t w;
    w.req_type = mbt_pkg::REQ_WRITE;
    w.pixel_row = r[7:0];
    w.pixel_col = c[7:0];
    w.pixel_value = v;
    send_word(w);
  endtask

  // step words carry random pixel fields, which the block must ignore
  task automatic send_step();
    mbt_pkg::in_word_t w;
    w = mbt_pkg::in_word_t'($urandom);
    w.req_type = mbt_pkg::REQ_STEP;
    send_word(w);
  endtask

  // drop start and wait until every expected word has come back
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // setup then access cycle; junk in the upper bits must be ignored
  task automatic cfg_write(logic [2:0] addr, int val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= {$urandom} & 32'hFFFF_FE00 | (val & 32'h1FF);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_size(int rows, int cols);
    drain();
    if ($urandom_range(0, 1)) begin
      cfg_write(ROWS_ADDR, rows);
      cfg_write(COLS_ADDR, cols);
    end else begin
      cfg_write(COLS_ADDR, cols);
      cfg_write(ROWS_ADDR, rows);
    end
    @(posedge clk);
  endtask

  // every pixel of the image in use is written before any step reads it
  task automatic paint(int rows, int cols, int shape);
    int r0, r1, c0, c1, sr, sc, dens;
    bit v;
    r0 = $urandom_range(0, rows - 1);
    r1 = $urandom_range(r0, rows - 1);
    c0 = $urandom_range(0, cols - 1);
    c1 = $urandom_range(c0, cols - 1);
    sr = $urandom_range(0, rows - 1);
    sc = $urandom_range(0, cols - 1);
    dens = $urandom_range(10, 90);
    for (int c = 0; c < cols; c++)
      for (int r = 0; r < rows; r++) begin
        case (shape)
          SHAPE_EMPTY:  v = 1'b0;
          SHAPE_FULL:   v = 1'b1;
          SHAPE_RECT:   v = (r >= r0 && r <= r1 && c >= c0 && c <= c1);
          SHAPE_BLOB:   v = (r >= r0 && r <= r1 && c >= c0 && c <= c1)
                            ? ($urandom_range(0, 99) < 92) : ($urandom_range(0, 99) < 4);
          SHAPE_SINGLE: v = (r == sr && c == sc);
          default:      v = ($urandom_range(0, 99) < dens);
        endcase
        send_pixel(r, c, v);
      end
  endtask

  // one setting: size, picture, a full trace, then mixed writes and steps
  task automatic run_phase(int rows, int cols, int shape, int extra);
    set_size(rows, cols);
    paint(rows, cols, shape);
    repeat (2 * (rows + cols) + 8) send_step();
    for (int i = 0; i < extra; i++) begin
      if ($urandom_range(0, 99) < 20) begin
        // mostly inside the image, sometimes anywhere in the store
        if ($urandom_range(0, 3) == 0)
          send_pixel($urandom_range(0, 255), $urandom_range(0, 255),
                     1'($urandom_range(0, 1)));
        else
          send_pixel($urandom_range(0, rows - 1), $urandom_range(0, cols - 1),
                     1'($urandom_range(0, 1)));
      end else begin
        send_step();
      end
    end
  endtask

  initial begin
    int rows, cols;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: smallest image, empty, corner pixel that dead-ends, store edges
    set_size(3, 3);
    paint(3, 3, SHAPE_EMPTY);
    send_step();
    send_step();
    send_pixel(2, 2, 1'b1);
    send_step();
    send_step();
    send_step();
    send_pixel(255, 255, 1'b1);
    send_pixel(255, 0, 1'b1);
    send_pixel(0, 255, 1'b1);
    send_pixel(0, 0, 1'b1);
    repeat (6) send_step();
    send_pixel(1, 1, 1'b1);
    repeat (8) send_step();

    run_phase(4, 4, SHAPE_SINGLE, 10);

    // random settings, small images to keep the word count down
    for (int p = 0; p < 6; p++) begin
      rows = $urandom_range(3, 7);
      cols = $urandom_range(3, 7);
      run_phase(rows, cols, $urandom_range(SHAPE_EMPTY, SHAPE_NOISE), 10);
    end

    // closing stretch runs with no gaps
    gaps_on = 1'b0;
    run_phase(5, 6, SHAPE_BLOB, 10);

    drain();
    repeat (200) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_moore_boundary_tracer OK");
    end else begin
      $display("tb_moore_boundary_tracer NOT OK");
    end
    $finish;
  end
endmodule
